// File: hw/rtl/hcd_pkg.sv
package hcd_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       chunk_end;
  } result_t;

  // {digit valid, digit value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/http_chunked_body_decoder_core.sv
// output: a result is registered in the output register, or in the skid register while the output stalls
// throughput: one byte per cycle; a stalled output is absorbed by a one-entry
//   skid register, so input stalls only when both output registers are full
// reset: synchronous rst returns the parser to the start of a size line and
//   empties the output registers
module http_chunked_body_decoder_core import hcd_pkg::*; #(
  parameter int SIZE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic       chunk_end
);

  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_fire = in_valid && in_ready;

  hcd_parser #(.SIZE_WIDTH(SIZE_WIDTH)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  hcd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && res_valid),
    .push_res  (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind      = out_res.kind;
  assign data      = out_res.data;
  assign chunk_end = out_res.chunk_end;

endmodule

// File: hw/rtl/hcd_parser.sv
module hcd_parser import hcd_pkg::*; #(
  parameter int SIZE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_SIZE, PH_EXT, PH_SIZE_LF, PH_DATA, PH_DATA_CR, PH_DATA_LF, PH_DONE, PH_RESYNC
  } phase_t;

  phase_t                  phase, phase_next;
  logic [SIZE_WIDTH-1:0]   size_accum, size_accum_next;
  logic [SIZE_WIDTH-1:0]   bytes_left, bytes_left_next;
  logic                    digit_seen, digit_seen_next;
  logic [4:0]              hex;
  logic [SIZE_WIDTH-1:0]   left_dec;
  logic                    is_lf;

  assign hex      = hex_decode(in_byte);
  assign is_lf    = (in_byte == CH_LF);
  assign left_dec = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;

  always_comb begin
    phase_next      = phase;
    size_accum_next = size_accum;
    bytes_left_next = bytes_left;
    digit_seen_next = digit_seen;
    res_valid       = 1'b0;
    res             = '{kind: KIND_ERR, data: 8'd0, chunk_end: 1'b0};

    unique case (phase)
      PH_SIZE: begin
        if (hex[4] && size_accum[SIZE_WIDTH-1 -: 4] == 4'd0) begin
          size_accum_next = {size_accum[SIZE_WIDTH-5:0], hex[3:0]};
          digit_seen_next = 1'b1;
        end else if (!hex[4] && in_byte == CH_SEMI && digit_seen) begin
          phase_next = PH_EXT;
        end else if (!hex[4] && in_byte == CH_CR && digit_seen) begin
          phase_next = PH_SIZE_LF;
        end else begin
          res_valid = 1'b1;
        end
      end
      PH_EXT: begin
        if (in_byte == CH_CR) phase_next = PH_SIZE_LF;
        else if (is_lf) res_valid = 1'b1;
      end
      PH_SIZE_LF: begin
        if (!is_lf) begin
          res_valid = 1'b1;
        end else begin
          digit_seen_next = 1'b0;
          if (size_accum == '0) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res.kind   = KIND_END;
          end else begin
            bytes_left_next = size_accum;
            size_accum_next = '0;
            phase_next      = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        bytes_left_next = left_dec;
        res_valid       = 1'b1;
        res.kind        = KIND_DATA;
        res.data        = in_byte;
        if (left_dec == '0) begin
          phase_next    = PH_DATA_CR;
          res.chunk_end = 1'b1;
        end
      end
      PH_DATA_CR: begin
        if (in_byte == CH_CR) phase_next = PH_DATA_LF;
        else res_valid = 1'b1;
      end
      PH_DATA_LF: begin
        if (is_lf) phase_next = PH_SIZE;
        else res_valid = 1'b1;
      end
      PH_DONE: begin
      end
      PH_RESYNC: begin
        if (is_lf) begin
          phase_next      = PH_SIZE;
          size_accum_next = '0;
          digit_seen_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // every error clears the size line and waits for the next lf; an lf that is itself the error restarts at once
    if (res_valid && res.kind == KIND_ERR) begin
      size_accum_next = '0;
      digit_seen_next = 1'b0;
      phase_next      = is_lf ? PH_SIZE : PH_RESYNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      size_accum <= '0;
      bytes_left <= '0;
      digit_seen <= 1'b0;
    end else if (in_fire) begin
      phase      <= phase_next;
      size_accum <= size_accum_next;
      bytes_left <= bytes_left_next;
      digit_seen <= digit_seen_next;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("left end-of-body phase");

  a_nondata_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != KIND_DATA |-> res.data == 8'd0 && !res.chunk_end)
    else $error("non-payload result carries data");

  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_DATA && bytes_left == SIZE_WIDTH'(1) |=> phase == PH_DATA_CR)
    else $error("chunk did not end after last byte");

endmodule

// File: hw/rtl/hcd_out_stage.sv
module hcd_out_stage import hcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;
  logic    pop;

  assign pop      = out_valid && out_ready;
  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_res <= skid_res;
    end else if (push) begin
      if (!out_valid || pop) out_res <= push_res;
      else skid_res <= push_res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result with empty output");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && push))
    else $error("skid filled without a stall");

endmodule

// File: tb/chunk_decode_checker.sv
module chunk_decode_checker import hcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data,
  input  logic       chunk_end,
  output int         fail_count,
  output int         pending
);

  localparam int SIZE_W = 32;

  typedef enum logic [2:0] {
    SZ_DIGITS, SZ_EXT, SZ_LF, PAYLOAD, PAY_CR, PAY_LF, BODY_DONE, RESYNC
  } parse_phase_t;

  parse_phase_t      phase_q;
  logic [SIZE_W-1:0] size_acc;
  logic [SIZE_W-1:0] remaining;
  logic              have_digit;
  result_t           due_q[$];
  int                mismatches = 0;

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // error drops the size line; an LF that is itself the culprit restarts at once
  task automatic raise_error(input logic [7:0] b, output bit emitted, output result_t r);
    size_acc   = '0;
    have_digit = 1'b0;
    phase_q    = (b == CH_LF) ? SZ_DIGITS : RESYNC;
    emitted    = 1'b1;
    r          = '{kind: KIND_ERR, data: 8'd0, chunk_end: 1'b0};
  endtask

  task automatic decode_byte(input logic [7:0] b, output bit emitted, output result_t r);
    int nib;
    emitted = 1'b0;
    r       = '0;
    nib     = nibble_of(b);
    case (phase_q)
      SZ_DIGITS: begin
        if (nib >= 0) begin
          // a further digit would push the size out of range
          if (size_acc[SIZE_W-1 -: 4] != 4'd0) begin
            raise_error(b, emitted, r);
          end else begin
            size_acc   = {size_acc[SIZE_W-5:0], nib[3:0]};
            have_digit = 1'b1;
          end
        end else if (b == CH_SEMI && have_digit) begin
          phase_q = SZ_EXT;
        end else if (b == CH_CR && have_digit) begin
          phase_q = SZ_LF;
        end else begin
          raise_error(b, emitted, r);
        end
      end
      SZ_EXT: begin
        if (b == CH_CR) begin
          phase_q = SZ_LF;
        end else if (b == CH_LF) begin
          raise_error(b, emitted, r);
        end
      end
      SZ_LF: begin
        if (b != CH_LF) begin
          raise_error(b, emitted, r);
        end else begin
          have_digit = 1'b0;
          if (size_acc == '0) begin
            phase_q = BODY_DONE;
            emitted = 1'b1;
            r       = '{kind: KIND_END, data: 8'd0, chunk_end: 1'b0};
          end else begin
            remaining = size_acc;
            size_acc  = '0;
            phase_q   = PAYLOAD;
          end
        end
      end
      PAYLOAD: begin
        if (remaining != '0) remaining = remaining - 1'b1;
        emitted = 1'b1;
        r       = '{kind: KIND_DATA, data: b, chunk_end: (remaining == '0)};
        if (remaining == '0) phase_q = PAY_CR;
      end
      PAY_CR: begin
        if (b == CH_CR) phase_q = PAY_LF;
        else raise_error(b, emitted, r);
      end
      PAY_LF: begin
        if (b == CH_LF) phase_q = SZ_DIGITS;
        else raise_error(b, emitted, r);
      end
      BODY_DONE: begin
      end
      default: begin
        if (b == CH_LF) begin
          phase_q    = SZ_DIGITS;
          size_acc   = '0;
          have_digit = 1'b0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    bit      emitted;
    if (rst) begin
      phase_q    = SZ_DIGITS;
      size_acc   = '0;
      remaining  = '0;
      have_digit = 1'b0;
      due_q.delete();
    end else begin
      // a result is registered before it leaves, so one leaving now is from an earlier byte; check it before predicting
      if (out_valid && out_ready) begin
        got = '{kind: kind, data: data, chunk_end: chunk_end};
        if (due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind=%0d data=%02h chunk_end=%0d",
                     got.kind, got.data, got.chunk_end);
        end else begin
          want = due_q.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.chunk_end !== want.chunk_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected kind=%0d data=%02h chunk_end=%0d",
                       want.kind, want.data, want.chunk_end);
              $display("  got kind=%0d data=%02h chunk_end=%0d",
                       got.kind, got.data, got.chunk_end);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_byte, emitted, want);
        if (emitted) due_q.push_back(want);
      end
    end
    fail_count = mismatches;
    pending    = due_q.size();
  end

endmodule

// File: tb/tb_http_chunked_body_decoder_core.sv
module tb_http_chunked_body_decoder_core import hcd_pkg::*;;

  localparam int RANDOM_BYTES = 1950;
  localparam int CYCLE_LIMIT  = 400000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'd0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [1:0] kind;
  wire  [7:0] data;
  wire        chunk_end;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          bytes_sent  = 0;
  bit          in_calm     = 1'b0;
  bit          out_calm    = 1'b0;
  int unsigned out_hold    = 0;
  int unsigned hold_next;

  http_chunked_body_decoder_core #(.SIZE_WIDTH(32)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data      (data),
    .chunk_end (chunk_end)
  );

  chunk_decode_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data       (data),
    .chunk_end  (chunk_end),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure, redrawn after every transfer
  always @(posedge clk) begin
    if (rst) begin
      out_hold  <= 0;
      out_ready <= 1'b0;
    end else begin
      hold_next = out_hold;
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        hold_next = out_calm ? 0 : $urandom_range(0, 15);
      end else if (out_hold != 0) begin
        hold_next = out_hold - 1;
      end
      out_hold  <= hold_next;
      out_ready <= (hold_next == 0);
    end
  end

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] hex_char(int unsigned nib, bit upper);
    if (nib < 10) return 8'("0" + nib);
    return 8'((upper ? "A" : "a") + nib - 10);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // one chunk: size line, optional extension, payload, closing CRLF;
  // a damaged chunk has one byte swapped for a non-hex value
  task automatic send_chunk(input int unsigned len, input bit damage);
    logic [7:0]  text[$];
    logic [7:0]  b;
    int unsigned pos;
    bit          upper;
    upper = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text.push_back("0");
    for (int i = 28; i >= 0; i -= 4)
      if ((len >> i) != 0) text.push_back(hex_char((len >> i) & 4'hf, upper));
    if ($urandom_range(0, 3) == 0) begin
      text.push_back(CH_SEMI);
      repeat ($urandom_range(0, 4)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        text.push_back(b);
      end
    end
    text.push_back(CH_CR);
    text.push_back(CH_LF);
    repeat (len) text.push_back(8'($urandom_range(0, 255)));
    text.push_back(CH_CR);
    text.push_back(CH_LF);
    if (damage) begin
      pos = $urandom_range(0, text.size() - 1);
      do b = 8'($urandom_range(0, 255)); while (is_hex_char(b) || b == text[pos]);
      text[pos] = b;
    end
    foreach (text[i]) send_byte(text[i]);
  endtask

  // garbage on a size line, closed by LF; no CR, so no size line can complete
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      do b = 8'($urandom_range(0, 255)); while (b == "0" || b == CH_CR);
      send_byte(b);
    end
    send_byte(CH_LF);
  endtask

  initial begin
    int start;
    int pick;
    int unsigned len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // stray byte on a size line
    send_text(" ");
    send_byte(CH_LF);
    // ';' with no digits, CR swallowed while resynchronising
    send_byte(CH_SEMI);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // CR with no digits
    send_byte(CH_CR);
    send_byte(CH_LF);
    // bare LF after a digit restarts straight away
    send_text("a");
    send_byte(CH_LF);
    // LF inside an extension
    send_text("1");
    send_byte(CH_SEMI);
    send_byte(CH_LF);
    // CR not followed by LF
    send_text("1");
    send_byte(CH_CR);
    send_text("X");
    send_byte(CH_LF);
    // ninth digit overflows 32 bits
    send_text("Fffffffff");
    send_byte(CH_LF);
    // leading zero, extension, single byte chunk
    send_text("01");
    send_byte(CH_SEMI);
    send_byte(8'hff);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(8'h00);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // payload not followed by CR
    send_text("2");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(8'hff);
    send_byte(CH_LF);
    send_text("X");
    send_byte(CH_LF);

    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      if (pick < 75) send_chunk(len, 1'b0);
      else if (pick < 90) send_chunk(len, 1'b1);
      else send_noise();
    end

    // zero-size terminator; everything after it is ignored
    send_text("X");
    send_byte(CH_LF);
    send_text("00");
    send_byte(CH_SEMI);
    send_text("end");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("1");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("z");
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/hcd_pkg.sv
hw/rtl/hcd_parser.sv
hw/rtl/hcd_out_stage.sv
hw/rtl/http_chunked_body_decoder_core.sv
tb/chunk_decode_checker.sv
tb/tb_http_chunked_body_decoder_core.sv
